// ===== hw/rtl/lrgd_pkg.sv =====
// Shared types, codes and saturation helpers for the gradient descent trainer.
// No dependencies; the divider, datapath, controller, top level and testbench import it.
package lrgd_pkg;

	// input commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_PRED  = 2'd2;

	// configuration register indexes
	localparam int         REG_IDX_W     = 4;
	localparam logic [3:0] REG_DIMS      = 4'd0;
	localparam logic [3:0] REG_ITER_LIM  = 4'd1;
	localparam logic [3:0] REG_BASE_RATE = 4'd2;
	localparam logic [3:0] REG_LOSS_LIM  = 4'd3;

	// register reset values
	localparam logic [3:0]  RST_DIMS      = 4'd2;
	localparam logic [15:0] RST_ITER_LIM  = 16'd1000;
	localparam logic [16:0] RST_BASE_RATE = 17'd6554;
	localparam logic [30:0] RST_LOSS_LIM  = 31'd6554;

	// learning rate decay: rate = base * SCALE / (SCALE + iteration)
	localparam int RATE_SCALE = 100;

	// result kinds
	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_PRED  = 1'b1;

	// divider dividend width
	localparam int NUM_W = 48;

	// datapath operations
	localparam int         OP_W      = 5;
	localparam logic [4:0] OP_NOP    = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_PCAP   = 5'd2;
	localparam logic [4:0] OP_PMUL   = 5'd3;
	localparam logic [4:0] OP_PACC   = 5'd4;
	localparam logic [4:0] OP_PEMIT  = 5'd5;
	localparam logic [4:0] OP_TINIT  = 5'd6;
	localparam logic [4:0] OP_RSTART = 5'd7;
	localparam logic [4:0] OP_RLATCH = 5'd8;
	localparam logic [4:0] OP_AMUL   = 5'd9;
	localparam logic [4:0] OP_AACC   = 5'd10;
	localparam logic [4:0] OP_ARES   = 5'd11;
	localparam logic [4:0] OP_BMUL   = 5'd12;
	localparam logic [4:0] OP_BACC   = 5'd13;
	localparam logic [4:0] OP_GDIV   = 5'd14;
	localparam logic [4:0] OP_MLATCH = 5'd15;
	localparam logic [4:0] OP_RMUL   = 5'd16;
	localparam logic [4:0] OP_WUPD   = 5'd17;
	localparam logic [4:0] OP_LDIV   = 5'd18;
	localparam logic [4:0] OP_BUPD   = 5'd19;
	localparam logic [4:0] OP_TEND   = 5'd20;
	localparam logic [4:0] OP_EW     = 5'd21;
	localparam logic [4:0] OP_EB     = 5'd22;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] feature;
		logic signed [31:0] label_value;
		logic               last_feature;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         index;
		logic signed [31:0] value;
		logic [15:0]        iterations;
		logic               converged;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] index;
		logic [31:0]          wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic i_last;
		logic j_last;
		logic div_done;
		logic out_free;
		logic has_samples;
		logic more_iter;
		logic conv_now;
		logic fin;
	} dp_stat_t;

	function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
		if (v[51:47] == {5{v[51]}})
			return v[47:0];
		return v[51] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v[51:31] == {21{v[51]}})
			return v[31:0];
		return v[51] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
	endfunction

endpackage

// ===== hw/rtl/lrgd_stream_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Payload types come from lrgd_pkg.
interface lrgd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lrgd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lrgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/lrgd_div.sv =====
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on lrgd_pkg (NUM_W).
module lrgd_div #(
	parameter int DW = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lrgd_pkg::NUM_W-1:0]   num_mag,
	input  logic                         neg,
	input  logic [DW-1:0]                den,
	output logic                         busy,
	output logic                         done,
	output logic signed [lrgd_pkg::NUM_W:0] quot
);
	import lrgd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q, den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DW:0]      trial;
	logic             take;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (int'(cnt_q) == NUM_W - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			neg_q <= neg;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ===== hw/rtl/lrgd_dp.sv =====
// Trainer datapath: config registers, parameter registers, sample/label/residual
// RAMs, shared multiplier, divider and output register. Depends on lrgd_pkg,
// lrgd_ram and lrgd_div.
module lrgd_dp #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_DIM     = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrgd_pkg::dp_cmd_t    cmd,
	output lrgd_pkg::dp_stat_t   stat,
	input  lrgd_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  lrgd_pkg::cfg_wr_t    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lrgd_pkg::out_item_t  out_data
);
	import lrgd_pkg::*;

	localparam int IW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int NW  = $clog2(MAX_DIM + 1);
	localparam int DVW = (CW > 17) ? CW : 17;

	// configuration
	logic [3:0]  dims_q;
	logic [15:0] ilim_q;
	logic [16:0] rate0_q;
	logic [30:0] llim_q;

	// model and bookkeeping state
	logic signed [31:0] weights_q [MAX_DIM];
	logic signed [31:0] bias_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      pos_q;
	logic signed [47:0] pacc_q;
	logic [15:0]        iters_q;
	logic               conv_q;

	// training work registers
	logic [15:0]        it_q;
	logic [IW-1:0]      i_q;
	logic [PW-1:0]      j_q;
	logic [16:0]        rate_q;
	logic signed [47:0] acc_q, loss_q, g_q;
	logic signed [31:0] mean_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] feat_q;
	logic               fin_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic [NW-1:0]      d;
	logic [PW-1:0]      pos_nx, widx;
	logic signed [31:0] w_sel, smp_rd, lab_rd, res_rd, res_new;
	logic [31:0]        smp_raw, lab_raw, res_raw;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_sh;
	logic signed [49:0] fx;
	logic               can_load, load_en, out_free, emit;
	logic signed [48:0] loss_abs;

	logic                   div_start, div_neg, div_busy, div_done;
	logic [NUM_W-1:0]       div_num;
	logic [DVW-1:0]         div_den;
	logic signed [NUM_W:0]  div_q;

	always_comb begin
		if (dims_q == '0)
			d = NW'(1);
		else if (int'(dims_q) > MAX_DIM)
			d = NW'(MAX_DIM);
		else
			d = NW'(dims_q);
	end

	assign pos_nx   = (int'(pos_q) + 1 >= MAX_DIM) ? '0 : PW'(pos_q + 1'b1);
	assign widx     = (cmd.op == OP_PMUL) ? pos_q : j_q;
	assign w_sel    = weights_q[widx];
	assign can_load = int'(count_q) < MAX_SAMPLES;
	assign load_en  = (cmd.op == OP_LOAD) && can_load;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (cmd.op == OP_PEMIT) || (cmd.op == OP_EW) || (cmd.op == OP_EB);

	// memories: samples are addressed {sample, feature position}
	lrgd_ram #(.WIDTH(32), .DEPTH((2 ** IW) * (2 ** PW))) u_smp_ram (
		.clk   (clk),
		.we    (load_en),
		.waddr ({count_q[IW-1:0], pos_q}),
		.wdata (in_data.feature),
		.raddr ({i_q, j_q}),
		.rdata (smp_raw)
	);

	lrgd_ram #(.WIDTH(32), .DEPTH(2 ** IW)) u_lab_ram (
		.clk   (clk),
		.we    (load_en && in_data.last_feature),
		.waddr (count_q[IW-1:0]),
		.wdata (in_data.label_value),
		.raddr (i_q),
		.rdata (lab_raw)
	);

	lrgd_ram #(.WIDTH(32), .DEPTH(2 ** IW)) u_res_ram (
		.clk   (clk),
		.we    (cmd.op == OP_ARES),
		.waddr (i_q),
		.wdata (res_new),
		.raddr (i_q),
		.rdata (res_raw)
	);

	assign smp_rd = $signed(smp_raw);
	assign lab_rd = $signed(lab_raw);
	assign res_rd = $signed(res_raw);

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_PMUL: begin
				ma = 33'(w_sel);
				mb = 33'(feat_q);
			end
			OP_AMUL: begin
				ma = 33'(w_sel);
				mb = 33'(smp_rd);
			end
			OP_BMUL: begin
				ma = 33'(smp_rd);
				mb = 33'(res_rd);
			end
			default: begin
				ma = $signed({16'b0, rate_q});
				mb = 33'(mean_q);
			end
		endcase
	end

	assign prod_sh = prod_q >>> FRAC_BITS;
	// clamp to 50 bits: anything larger saturates the following 48/32-bit sum anyway
	assign fx      = (prod_sh[65:49] == {17{prod_sh[65]}}) ? prod_sh[49:0]
		: {prod_sh[65], {49{!prod_sh[65]}}};
	assign res_new = sat32(52'(acc_q) + 52'(bias_q) - 52'(lab_rd));
	assign loss_abs = loss_q[47] ? -49'(loss_q) : 49'(loss_q);

	// divider operands
	always_comb begin
		div_start = 1'b0;
		div_neg   = 1'b0;
		div_num   = 48'(rate0_q) * 48'(RATE_SCALE);
		div_den   = DVW'(17'(it_q) + 17'(RATE_SCALE + 1));
		case (cmd.op)
			OP_RSTART: div_start = 1'b1;
			OP_GDIV: begin
				div_start = 1'b1;
				div_neg   = g_q[47];
				div_num   = g_q[47] ? NUM_W'(-g_q) : NUM_W'(g_q);
				div_den   = DVW'(count_q);
			end
			OP_LDIV: begin
				div_start = 1'b1;
				div_neg   = loss_q[47];
				div_num   = loss_q[47] ? NUM_W'(-loss_q) : NUM_W'(loss_q);
				div_den   = DVW'(count_q);
			end
			default: ;
		endcase
	end

	lrgd_div #(.DW(DVW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (div_num),
		.neg     (div_neg),
		.den     (div_den),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (div_q)
	);

	// control and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q      <= RST_DIMS;
			ilim_q      <= RST_ITER_LIM;
			rate0_q     <= RST_BASE_RATE;
			llim_q      <= RST_LOSS_LIM;
			for (int k = 0; k < MAX_DIM; k++)
				weights_q[k] <= '0;
			bias_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			pacc_q      <= '0;
			iters_q     <= '0;
			conv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_data.index)
					REG_DIMS:      dims_q  <= cfg_data.wdata[3:0];
					REG_ITER_LIM:  ilim_q  <= cfg_data.wdata[15:0];
					REG_BASE_RATE: rate0_q <= cfg_data.wdata[16:0];
					REG_LOSS_LIM:  llim_q  <= cfg_data.wdata[30:0];
					default: ;
				endcase
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					pos_q <= in_data.last_feature ? '0 : pos_nx;
					if (can_load && in_data.last_feature)
						count_q <= count_q + 1'b1;
				end
				OP_PACC: begin
					if (int'(pos_q) < int'(d))
						pacc_q <= sat48(52'(pacc_q) + 52'(fx));
					if (!fin_q)
						pos_q <= pos_nx;
				end
				OP_PEMIT: begin
					pacc_q <= '0;
					pos_q  <= '0;
				end
				OP_TINIT: conv_q <= 1'b0;
				OP_WUPD:  weights_q[j_q] <= sat32(52'(w_sel) - 52'(fx));
				OP_BUPD: begin
					bias_q <= sat32(52'(bias_q) - 52'(fx));
					if (stat.conv_now)
						conv_q <= 1'b1;
				end
				OP_TEND:  iters_q <= it_q;
				default: ;
			endcase
		end
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PCAP: begin
				feat_q <= in_data.feature;
				fin_q  <= in_data.last_feature;
			end
			OP_PMUL, OP_AMUL, OP_BMUL, OP_RMUL: prod_q <= ma * mb;
			OP_TINIT: begin
				it_q <= '0;
				i_q  <= '0;
				j_q  <= '0;
			end
			OP_RLATCH: begin
				rate_q <= div_q[16:0];
				it_q   <= it_q + 1'b1;
				acc_q  <= '0;
				loss_q <= '0;
				g_q    <= '0;
			end
			OP_AACC: begin
				acc_q <= sat48(52'(acc_q) + 52'(fx));
				j_q   <= stat.j_last ? '0 : PW'(j_q + 1'b1);
			end
			OP_ARES: begin
				loss_q <= sat48(52'(loss_q) + 52'(res_new));
				acc_q  <= '0;
				i_q    <= stat.i_last ? '0 : IW'(i_q + 1'b1);
			end
			OP_BACC: begin
				g_q <= sat48(52'(g_q) + 52'(fx));
				i_q <= stat.i_last ? '0 : IW'(i_q + 1'b1);
			end
			OP_MLATCH: mean_q <= sat32(52'(div_q));
			OP_WUPD: begin
				g_q <= '0;
				j_q <= stat.j_last ? '0 : PW'(j_q + 1'b1);
			end
			OP_EW: begin
				out_q <= '{kind: KIND_PARAM, index: 4'(j_q), value: w_sel,
					iterations: iters_q, converged: conv_q, last: 1'b0};
				j_q   <= stat.j_last ? '0 : PW'(j_q + 1'b1);
			end
			OP_EB: out_q <= '{kind: KIND_PARAM, index: 4'(MAX_DIM), value: bias_q,
					iterations: iters_q, converged: conv_q, last: 1'b1};
			OP_PEMIT: out_q <= '{kind: KIND_PRED, index: 4'd0,
					value: sat32(52'(pacc_q) + 52'(bias_q)),
					iterations: iters_q, converged: 1'b0, last: 1'b1};
			default: ;
		endcase
	end

	assign stat.i_last      = int'(i_q) == int'(count_q) - 1;
	assign stat.j_last      = int'(j_q) == int'(d) - 1;
	assign stat.div_done    = div_done;
	assign stat.out_free    = out_free;
	assign stat.has_samples = count_q != '0;
	assign stat.more_iter   = it_q < ilim_q;
	assign stat.conv_now    = loss_abs < 49'(llim_q);
	assign stat.fin         = fin_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EW || cmd.op == OP_EB || cmd.op == OP_PEMIT) |-> out_free)
		else $error("result written over a pending result");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < MAX_DIM)
		else $error("feature position out of range");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_SAMPLES)
		else $error("sample count out of range");
`endif
endmodule

// ===== hw/rtl/lrgd_ctrl.sv =====
// Trainer controller: sequences load, predict, training passes and emission.
// Depends on lrgd_pkg (op codes, command and status structs).
module lrgd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic [1:0]         item_cmd,
	output logic               item_ready,
	input  lrgd_pkg::dp_stat_t stat,
	output lrgd_pkg::dp_cmd_t  cmd
);
	import lrgd_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_P_MUL  = 5'd1;
	localparam logic [4:0] S_P_ACC  = 5'd2;
	localparam logic [4:0] S_P_OUT  = 5'd3;
	localparam logic [4:0] S_T_INIT = 5'd4;
	localparam logic [4:0] S_T_CHK  = 5'd5;
	localparam logic [4:0] S_R_GO   = 5'd6;
	localparam logic [4:0] S_R_WAIT = 5'd7;
	localparam logic [4:0] S_A_RD   = 5'd8;
	localparam logic [4:0] S_A_MUL  = 5'd9;
	localparam logic [4:0] S_A_ACC  = 5'd10;
	localparam logic [4:0] S_A_RES  = 5'd11;
	localparam logic [4:0] S_B_RD   = 5'd12;
	localparam logic [4:0] S_B_MUL  = 5'd13;
	localparam logic [4:0] S_B_ACC  = 5'd14;
	localparam logic [4:0] S_G_DIV  = 5'd15;
	localparam logic [4:0] S_G_WAIT = 5'd16;
	localparam logic [4:0] S_W_MUL  = 5'd17;
	localparam logic [4:0] S_W_UPD  = 5'd18;
	localparam logic [4:0] S_L_DIV  = 5'd19;
	localparam logic [4:0] S_L_WAIT = 5'd20;
	localparam logic [4:0] S_L_MUL  = 5'd21;
	localparam logic [4:0] S_L_UPD  = 5'd22;
	localparam logic [4:0] S_T_END  = 5'd23;
	localparam logic [4:0] S_E_W    = 5'd24;
	localparam logic [4:0] S_E_B    = 5'd25;

	logic [4:0] state_q, state_nx;

	always_comb begin
		state_nx   = state_q;
		cmd.op     = OP_NOP;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (item_cmd)
						CMD_LOAD:  cmd.op = OP_LOAD;
						CMD_TRAIN: state_nx = S_T_INIT;
						CMD_PRED: begin
							cmd.op   = OP_PCAP;
							state_nx = S_P_MUL;
						end
						default: ;
					endcase
				end
			end
			S_P_MUL: begin
				cmd.op   = OP_PMUL;
				state_nx = S_P_ACC;
			end
			S_P_ACC: begin
				cmd.op   = OP_PACC;
				state_nx = stat.fin ? S_P_OUT : S_IDLE;
			end
			S_P_OUT: if (stat.out_free) begin
				cmd.op   = OP_PEMIT;
				state_nx = S_IDLE;
			end
			S_T_INIT: begin
				cmd.op   = OP_TINIT;
				state_nx = S_T_CHK;
			end
			S_T_CHK: state_nx = (stat.has_samples && stat.more_iter) ? S_R_GO : S_T_END;
			S_R_GO: begin
				cmd.op   = OP_RSTART;
				state_nx = S_R_WAIT;
			end
			S_R_WAIT: if (stat.div_done) begin
				cmd.op   = OP_RLATCH;
				state_nx = S_A_RD;
			end
			S_A_RD: state_nx = S_A_MUL;
			S_A_MUL: begin
				cmd.op   = OP_AMUL;
				state_nx = S_A_ACC;
			end
			S_A_ACC: begin
				cmd.op   = OP_AACC;
				state_nx = stat.j_last ? S_A_RES : S_A_RD;
			end
			S_A_RES: begin
				cmd.op   = OP_ARES;
				state_nx = stat.i_last ? S_B_RD : S_A_RD;
			end
			S_B_RD: state_nx = S_B_MUL;
			S_B_MUL: begin
				cmd.op   = OP_BMUL;
				state_nx = S_B_ACC;
			end
			S_B_ACC: begin
				cmd.op   = OP_BACC;
				state_nx = stat.i_last ? S_G_DIV : S_B_RD;
			end
			S_G_DIV: begin
				cmd.op   = OP_GDIV;
				state_nx = S_G_WAIT;
			end
			S_G_WAIT: if (stat.div_done) begin
				cmd.op   = OP_MLATCH;
				state_nx = S_W_MUL;
			end
			S_W_MUL: begin
				cmd.op   = OP_RMUL;
				state_nx = S_W_UPD;
			end
			S_W_UPD: begin
				cmd.op   = OP_WUPD;
				state_nx = stat.j_last ? S_L_DIV : S_B_RD;
			end
			S_L_DIV: begin
				cmd.op   = OP_LDIV;
				state_nx = S_L_WAIT;
			end
			S_L_WAIT: if (stat.div_done) begin
				cmd.op   = OP_MLATCH;
				state_nx = S_L_MUL;
			end
			S_L_MUL: begin
				cmd.op   = OP_RMUL;
				state_nx = S_L_UPD;
			end
			S_L_UPD: begin
				cmd.op = OP_BUPD;
				if (stat.conv_now || !stat.more_iter)
					state_nx = S_T_END;
				else
					state_nx = S_R_GO;
			end
			S_T_END: begin
				cmd.op   = OP_TEND;
				state_nx = S_E_W;
			end
			S_E_W: if (stat.out_free) begin
				cmd.op   = OP_EW;
				state_nx = stat.j_last ? S_E_B : S_E_W;
			end
			S_E_B: if (stat.out_free) begin
				cmd.op   = OP_EB;
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

`ifndef SYNTH
	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_R_WAIT && !stat.div_done) |=> state_q == S_R_WAIT)
		else $error("left rate wait before divider finished");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E_B && !stat.out_free) |=> state_q == S_E_B)
		else $error("bias emission skipped while output busy");
	a_train_go: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && item_valid && item_cmd == CMD_TRAIN) |=> state_q == S_T_INIT)
		else $error("train command not started");
`endif
endmodule

// ===== hw/rtl/linear_regression_gd_trainer_top.sv =====
// Top level of the batch gradient descent linear regression trainer.
// Depends on lrgd_pkg, lrgd_stream_if, lrgd_ctrl, lrgd_dp (lrgd_ram, lrgd_div).
//
//  channel | dir | payload                                      | transaction
//  --------+-----+----------------------------------------------+--------------------
//  cfg     | in  | index, wdata                                 | one register write
//  item    | in  | cmd, feature, label_value, last_feature      | one feature / command
//  result  | out | kind, index, value, iterations, converged, last | one parameter/prediction
//
// Load transactions are handled in the idle state. A predict element is captured,
// multiplied by its weight in the shared multiplier and accumulated; the closing element also emits.
// A training run does per iteration a rate divide, a residual per sample over d features,
// a gradient, divide and update per weight, and a loss divide and bias update, through the
// single multiplier and the 48-step serial divider; then d+1 result transactions follow.
// The item channel is ready only while the controller is idle; a waiting result
// sits in the output register and only a closing prediction or a parameter
// emission waits for it to drain.
// arst_n clears model parameters, counters and config to their defaults; the
// sample, label and residual RAMs are not cleared.
module linear_regression_gd_trainer_top #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_DIM     = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lrgd_stream_if.sink          cfg,
	lrgd_stream_if.sink          item,
	lrgd_stream_if.source        result
);
	import lrgd_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	logic      item_ready;
	in_item_t  in_data;
	cfg_wr_t   cfg_data;
	out_item_t out_data;
	logic      out_valid;

	// config writes are always taken; software writes them only while idle
	assign cfg.ready = 1'b1;
	assign cfg_data  = cfg.data;
	assign in_data   = item.data;
	assign item.ready = item_ready;

	lrgd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_cmd   (in_data.cmd),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lrgd_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_DIM     (MAX_DIM),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	// result goes straight from the datapath output register
	assign result.valid = out_valid;
	assign result.data  = out_data;
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for linear_regression_gd_trainer_top.
// Depends on lrgd_pkg and lrgd_stream_if; a shadow trainer predicts every result.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lrgd_pkg::*;

	localparam int N_SLOTS = 256;
	localparam int N_DIM   = 8;
	localparam int FRAC    = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Shadow of the trainer: its own parameters, stores and registers, plus the
	// queue of results the block owes us.
	class trainer_shadow;
		int          samples [N_SLOTS*N_DIM];
		int          labels  [N_SLOTS];
		longint      resid   [N_SLOTS];
		longint      weights [N_DIM];
		longint      bias;
		int unsigned n_loaded;
		int unsigned pos;
		longint      pacc;
		int unsigned last_iters;
		bit          last_conv;
		int unsigned dims_reg, iter_lim, base_rate, loss_lim;
		out_item_t   owed_results[$];

		function new();
			foreach (samples[i]) samples[i] = 0;
			foreach (labels[i]) labels[i] = 0;
			foreach (resid[i]) resid[i] = 0;
			foreach (weights[i]) weights[i] = 0;
			bias = 0; n_loaded = 0; pos = 0; pacc = 0;
			last_iters = 0; last_conv = 0;
			dims_reg = RST_DIMS; iter_lim = RST_ITER_LIM;
			base_rate = RST_BASE_RATE; loss_lim = RST_LOSS_LIM;
		endfunction

		function longint sat(longint v, int bits);
			longint lim;
			lim = 64'sd1 <<< (bits - 1);
			if (v > lim - 1) return lim - 1;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// exact product, floor shift
		function longint fmul(longint a, longint b);
			return (a * b) >>> FRAC;
		endfunction

		function int unsigned dims_used();
			if (dims_reg == 0) return 1;
			if (dims_reg > N_DIM) return N_DIM;
			return dims_reg;
		endfunction

		function void write_reg(logic [3:0] idx, logic [31:0] val);
			case (idx)
				REG_DIMS:      dims_reg  = val[3:0];
				REG_ITER_LIM:  iter_lim  = val[15:0];
				REG_BASE_RATE: base_rate = val[16:0];
				REG_LOSS_LIM:  loss_lim  = val[30:0];
				default: ;
			endcase
		endfunction

		function void push(logic kind, int unsigned idx, longint val, bit conv, bit fin);
			out_item_t r;
			r.kind = kind;
			r.index = idx[3:0];
			r.value = val[31:0];
			r.iterations = last_iters[15:0];
			r.converged = conv;
			r.last = fin;
			owed_results.insert(owed_results.size(), r);
		endfunction

		function void train_run();
			int unsigned d, n, it, i, j;
			longint rate, loss, g, acc, mean, absl;
			bit conv;
			d = dims_used(); n = n_loaded; it = 0; conv = 0;
			if (n > 0) begin
				while (it < iter_lim) begin
					it++;
					rate = longint'((64'(base_rate) * 100) / (100 + it));
					for (i = 0; i < n; i++) begin
						acc = 0;
						for (j = 0; j < d; j++)
							acc = sat(acc + fmul(weights[j], samples[i*N_DIM+j]), 48);
						resid[i] = sat(acc + bias - labels[i], 32);
					end
					for (j = 0; j < d; j++) begin
						g = 0;
						for (i = 0; i < n; i++)
							g = sat(g + fmul(samples[i*N_DIM+j], resid[i]), 48);
						mean = sat(g / longint'(n), 32);
						weights[j] = sat(weights[j] - fmul(rate, mean), 32);
					end
					loss = 0;
					for (i = 0; i < n; i++)
						loss = sat(loss + resid[i], 48);
					mean = sat(loss / longint'(n), 32);
					bias = sat(bias - fmul(rate, mean), 32);
					absl = (loss < 0) ? -loss : loss;
					if (absl < longint'(loss_lim)) begin
						conv = 1;
						break;
					end
				end
			end
			last_iters = it & 16'hFFFF;
			last_conv = conv;
		endfunction

		// accepted input transaction
		function void note_item(in_item_t t);
			longint feat, lab, v;
			int unsigned d, j;
			feat = longint'(t.feature);
			lab = longint'(t.label_value);
			d = dims_used();
			case (t.cmd)
				CMD_LOAD: begin
					if (n_loaded < N_SLOTS) begin
						samples[n_loaded*N_DIM+pos] = int'(feat);
						if (t.last_feature) begin
							labels[n_loaded] = int'(lab);
							n_loaded++;
						end
					end
					pos = t.last_feature ? 0 : ((pos + 1 >= N_DIM) ? 0 : pos + 1);
				end
				CMD_TRAIN: begin
					train_run();
					for (j = 0; j < d; j++)
						push(KIND_PARAM, j, weights[j], last_conv, 0);
					push(KIND_PARAM, N_DIM, bias, last_conv, 1);
				end
				CMD_PRED: begin
					if (pos < d)
						pacc = sat(pacc + fmul(weights[pos], feat), 48);
					if (t.last_feature) begin
						v = sat(pacc + bias, 32);
						pacc = 0;
						pos = 0;
						push(KIND_PRED, 0, v, 0, 1);
					end else begin
						pos = (pos + 1 >= N_DIM) ? 0 : pos + 1;
					end
				end
				default: ;
			endcase
		endfunction

		// returns an empty string on a match
		function string check_result(out_item_t r);
			out_item_t e;
			if (owed_results.size() == 0)
				return $sformatf("unexpected result kind=%0d index=%0d value=%0d",
					r.kind, r.index, r.value);
			e = owed_results.pop_front();
			if (r !== e)
				return $sformatf({"result mismatch: got k%0d i%0d v%0d it%0d c%0d l%0d,",
					" want k%0d i%0d v%0d it%0d c%0d l%0d"},
					r.kind, r.index, r.value, r.iterations, r.converged, r.last,
					e.kind, e.index, e.value, e.iterations, e.converged, e.last);
			return "";
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   fail_count;
	int   burst_left;
	int   stall_left;
	int   stall_mode;
	trainer_shadow shadow;

	lrgd_stream_if #(.T(cfg_wr_t))   cfg_if ();
	lrgd_stream_if #(.T(in_item_t))  item_if ();
	lrgd_stream_if #(.T(out_item_t)) res_if ();

	linear_regression_gd_trainer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.item   (item_if),
		.result (res_if)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Result side: stall pattern switches at random between four modes - always ready,
	// coin flip, mostly stalled, mostly ready.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= $urandom_range(0, 1);
			2: res_if.ready <= ($urandom_range(0, 9) == 0);
			default: res_if.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// every result transaction is checked against the oldest owed one
	always @(posedge clk) begin
		string msg;
		if (arst_n && res_if.valid && res_if.ready) begin
			msg = shadow.check_result(res_if.data);
			if (msg != "") report(msg);
		end
	end

	function automatic in_item_t mk_item(logic [1:0] c, logic [31:0] f, logic [31:0] l,
			logic fin);
		in_item_t t;
		t.cmd = c;
		t.feature = f;
		t.label_value = l;
		t.last_feature = fin;
		return t;
	endfunction

	// Q16.16 value in about +-2.0, or anything when wide is set
	function automatic logic [31:0] rand_fx(bit wide);
		if (wide) return $urandom;
		return $urandom_range(0, 32'h40000) - 32'h20000;
	endfunction

	// Sender works in bursts; between bursts a gap may drop valid. Called and
	// returns at a falling edge.
	task automatic send_item(in_item_t t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		item_if.valid <= 1'b1;
		item_if.data  <= t;
		do @(posedge clk); while (!item_if.ready);
		shadow.note_item(t);
		burst_left--;
		@(negedge clk);
	endtask

	// Wait until every owed result is in, then let the block settle.
	task automatic settle();
		item_if.valid <= 1'b0;
		while (shadow.owed_results.size() != 0) @(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		cfg_wr_t w;
		w.index = idx;
		w.wdata = val;
		item_if.valid <= 1'b0;
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= w;
		do @(posedge clk); while (!cfg_if.ready);
		shadow.write_reg(idx, val);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Samples of MAX_DIM or more features fill every store slot that training
	// reads whatever the dimension setting; shorter ones only with a matching
	// dimension count and a start at position zero.
	task automatic load_sample(int nf, bit wide);
		for (int k = 0; k < nf; k++)
			send_item(mk_item(CMD_LOAD, rand_fx(wide), rand_fx(wide), k == nf - 1));
	endtask

	task automatic predict_seq(int nf, bit wide);
		for (int k = 0; k < nf; k++)
			send_item(mk_item(CMD_PRED, rand_fx(wide), $urandom, k == nf - 1));
	endtask

	task automatic train();
		send_item(mk_item(CMD_TRAIN, $urandom, $urandom, $urandom_range(0, 1)));
	endtask

	initial begin
		#50_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		int counted;
		int pick;
		int nf;
		shadow = new();
		fail_count = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		res_if.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// --- directed ---
		// training before any sample: parameters come back unchanged
		train();
		// prediction with zero weights, then the unused command
		predict_seq(3, 1);
		send_item(mk_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		settle();
		// dimension register below and above its range
		write_reg(REG_DIMS, 32'd0);
		train();
		settle();
		write_reg(REG_DIMS, 32'hFFFF_FFFF);
		train();
		settle();
		// small samples, huge iteration limit, loss limit at max: stops at once
		load_sample(8, 0);
		load_sample(8, 0);
		write_reg(REG_ITER_LIM, 32'd65535);
		write_reg(REG_LOSS_LIM, 32'h7FFF_FFFF);
		write_reg(REG_BASE_RATE, 32'd0);
		train();
		settle();
		// zero iteration limit: no iterations
		write_reg(REG_ITER_LIM, 32'd0);
		train();
		settle();
		// field extremes, rate of one, loss limit zero, one iteration
		send_item(mk_item(CMD_LOAD, 32'h8000_0000, 32'h0, 1'b0));
		send_item(mk_item(CMD_LOAD, 32'h7FFF_FFFF, 32'h0, 1'b0));
		send_item(mk_item(CMD_LOAD, 32'h0, 32'h0, 1'b0));
		for (int k = 0; k < 4; k++)
			send_item(mk_item(CMD_LOAD, rand_fx(1), rand_fx(1), 1'b0));
		send_item(mk_item(CMD_LOAD, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
		settle();
		write_reg(REG_ITER_LIM, 32'd1);
		write_reg(REG_BASE_RATE, 32'd65536);
		write_reg(REG_LOSS_LIM, 32'd0);
		train();
		// prediction longer than MAX_DIM: position wraps, extras accumulate again with the first weights
		predict_seq(10, 1);
		settle();

		// --- random ---
		counted = 0;
		while (counted < 50) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				nf = $urandom_range(8, 10);
				load_sample(nf, $urandom_range(0, 9) == 0);
				counted += nf;
			end else if (pick < 75) begin
				nf = $urandom_range(1, 10);
				predict_seq(nf, $urandom_range(0, 4) == 0);
				counted += nf;
			end else if (pick < 85) begin
				train();
				counted++;
				if ($urandom_range(0, 2) == 0) begin
					settle();
					case ($urandom_range(0, 3))
						0: write_reg(REG_DIMS, ($urandom_range(0, 9) == 0) ?
							$urandom_range(0, 15) : $urandom_range(1, 8));
						1: write_reg(REG_ITER_LIM, $urandom_range(1, 16));
						2: write_reg(REG_BASE_RATE, ($urandom_range(0, 4) == 0) ?
							32'd65536 : $urandom_range(0, 65536));
						default: write_reg(REG_LOSS_LIM, ($urandom_range(0, 4) == 0) ?
							32'd0 : $urandom_range(0, 32'h0010_0000));
					endcase
				end
			end else if (pick < 92) begin
				// broken sequence: a stray load that never closes a sample
				send_item(mk_item(CMD_LOAD, $urandom, $urandom, 1'b0));
				counted++;
			end else if (pick < 97) begin
				send_item(mk_item(CMD_PRED, $urandom, $urandom, $urandom_range(0, 1)));
				counted++;
			end else begin
				send_item(mk_item(CMD_UNUSED, $urandom, $urandom, $urandom_range(0, 1)));
				counted++;
			end
		end
		settle();

		// --- full sample store: later loads are dropped ---
		// one-feature samples with one used dimension; a closing prediction
		// puts the shared position back to zero first
		write_reg(REG_ITER_LIM, 32'd1);
		write_reg(REG_DIMS, 32'd1);
		predict_seq(1, 0);
		while (shadow.n_loaded < N_SLOTS)
			load_sample(1, 0);
		for (int s = 0; s < 4; s++)
			load_sample(1, 0);
		train();
		predict_seq(8, 0);
		settle();

		repeat (200) @(negedge clk);
		if (fail_count == 0 && shadow.owed_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
